// ===== rtl/mbs_pkg.sv =====
// shared types, codes and constants for the scanline counter bank-switch mapper
package mbs_pkg;

    // item kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_CPU_WRITE = 2'd0,
        MODE_CPU_READ  = 2'd1,
        MODE_CPU_TICK  = 2'd2,
        MODE_PPU       = 2'd3
    } mode_t;

    // work-ram decision codes
    typedef enum logic [2:0] {
        WRAM_NONE      = 3'd0,
        WRAM_READ_RAM  = 3'd1,
        WRAM_READ_ZERO = 3'd2,
        WRAM_OPEN_BUS  = 3'd3,
        WRAM_WRITE_RAM = 3'd4,
        WRAM_BLOCKED   = 3'd5
    } wram_action_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRG_AND = 2'd0,
        CFG_PRG_OR  = 2'd1,
        CFG_CHR_AND = 2'd2,
        CFG_CHR_OR  = 2'd3
    } cfg_index_t;

    // mapper register groups, cpu_addr[15:13]
    localparam logic [2:0] GRP_BANK   = 3'b100;
    localparam logic [2:0] GRP_MIRROR = 3'b101;
    localparam logic [2:0] GRP_RELOAD = 3'b110;
    localparam logic [2:0] GRP_IRQ    = 3'b111;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;

    // a12 low-pass hold time in cpu ticks
    localparam logic [2:0] FILTER_CYCLES = 3'd5;

    localparam logic [3:0] WRAM_PAGE    = 4'h7;
    localparam logic [6:0] PRG_FIXED_HI = 7'h7F;

    typedef logic [7:0] byte_t;
    localparam byte_t BANK_INIT [8] = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1};

    // result word, prg_bank in the low bits
    typedef struct packed {
        logic         pad;
        logic         mirror_horizontal;
        logic         irq_active;
        logic [9:0]   wram_offset;
        wram_action_t wram_action;
        byte_t        chr_bank;
        byte_t        prg_bank;
    } result_t;

endpackage

// ===== rtl/mapper_bank_switch_scanline_irq.sv =====
// scanline counter bank-switch mapper: register file, counter, bank lookup, output buffer
// results are registered in the output register, or in the skid entry while it is held
// one word per cycle unless the skid entry is full; update and lookup are one shallow pass
// output register plus skid entry, so input keeps flowing in a stall until the skid fills
// reset: bank pointer, mirroring, protection, counter, reload, irq and filter clear to zero,
// bank registers load 0,2,4,5,6,7,0,1, and and/or masks load 255/0
module mapper_bank_switch_scanline_irq (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_we,
    input  logic [mbs_pkg::CFG_INDEX_W-1:0]  cfg_addr,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mbs_pkg::IN_TDATA_W-1:0]   s_tdata,   // cpu_addr, write_data, ppu_addr, zero pad
    input  logic [1:0]                       s_tuser,   // mode
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mbs_pkg::OUT_TDATA_W-1:0]  m_tdata    // prg_bank, chr_bank, wram_action,
                                                        // wram_offset, irq_active,
                                                        // mirror_horizontal, zero pad
);
    import mbs_pkg::*;

    // config registers
    byte_t prg_and_reg, prg_or_reg, chr_and_reg, chr_or_reg;

    // mapper state
    byte_t       bank_pointer_reg, bank_pointer_next;
    byte_t       bank_regs_reg  [8];
    byte_t       bank_regs_next [8];
    logic        mirror_reg, mirror_next;
    logic [3:0]  protect_reg, protect_next;
    byte_t       counter_reg, counter_next;
    byte_t       reload_reg, reload_next;
    logic        irq_enable_reg, irq_enable_next;
    logic        irq_pending_reg, irq_pending_next;
    logic [2:0]  filter_reg, filter_next;

    // output buffer
    logic        out_valid_reg, skid_valid_reg;
    result_t     out_data_reg, skid_data_reg;
    result_t     result;

    logic        in_fire, out_free;
    mode_t       mode;
    logic [15:0] cpu_addr;
    byte_t       write_data;
    logic [13:0] ppu_addr;

    assign mode       = mode_t'(s_tuser);
    assign cpu_addr   = s_tdata[15:0];
    assign write_data = s_tdata[23:16];
    assign ppu_addr   = s_tdata[37:24];

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_and_reg <= 8'hFF;
            prg_or_reg  <= 8'h00;
            chr_and_reg <= 8'hFF;
            chr_or_reg  <= 8'h00;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_PRG_AND: prg_and_reg <= cfg_wdata;
                CFG_PRG_OR:  prg_or_reg  <= cfg_wdata;
                CFG_CHR_AND: chr_and_reg <= cfg_wdata;
                CFG_CHR_OR:  chr_or_reg  <= cfg_wdata;
            endcase
        end
    end

    // state update for one word
    always_comb
    begin
        logic        odd;
        byte_t       cnt_step;
        bank_pointer_next = bank_pointer_reg;
        bank_regs_next    = bank_regs_reg;
        mirror_next       = mirror_reg;
        protect_next      = protect_reg;
        counter_next      = counter_reg;
        reload_next       = reload_reg;
        irq_enable_next   = irq_enable_reg;
        irq_pending_next  = irq_pending_reg;
        filter_next       = filter_reg;
        odd               = cpu_addr[0];
        cnt_step          = (counter_reg == 8'd0) ? reload_reg : counter_reg - 8'd1;

        unique case (mode)
            MODE_CPU_WRITE:
            begin
                if (cpu_addr[15])
                begin
                    unique case (cpu_addr[15:13])
                        GRP_BANK:
                        begin
                            if (odd)
                                bank_regs_next[bank_pointer_reg[2:0]] = write_data;
                            else
                                bank_pointer_next = write_data;
                            if (!bank_pointer_next[5])
                                protect_next = 4'd0;
                        end
                        GRP_MIRROR:
                        begin
                            if (odd)
                                protect_next = write_data[7:4];
                            else
                                mirror_next = write_data[0];
                            if (!bank_pointer_reg[5])
                                protect_next = 4'd0;
                        end
                        GRP_RELOAD:
                        begin
                            if (odd)
                                counter_next = 8'd0;
                            else
                                reload_next = write_data;
                        end
                        GRP_IRQ:
                        begin
                            irq_enable_next = odd;
                            if (!odd)
                                irq_pending_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            MODE_CPU_READ:
            begin
            end
            MODE_CPU_TICK:
            begin
                if (filter_reg != 3'd0)
                    filter_next = filter_reg - 3'd1;
            end
            MODE_PPU:
            begin
                if (ppu_addr[12])
                begin
                    if (filter_reg == 3'd0)
                    begin
                        counter_next = cnt_step;
                        if (cnt_step == 8'd0 && irq_enable_reg)
                            irq_pending_next = 1'b1;
                    end
                    filter_next = FILTER_CYCLES;
                end
            end
        endcase
    end

    // bank lookup on the updated state, and the work-ram decision
    always_comb
    begin
        logic [1:0] prg_slot;
        logic [2:0] chr_slot;
        byte_t      prg_raw, chr_raw;
        logic       in_wram, high_half, rd_this, rd_other, wr_this;

        // prg: slots 2 and 3 fixed at the last two banks, pointer bit 6 swaps 0 and 2
        prg_slot = cpu_addr[14:13];
        if (!prg_slot[0] && bank_pointer_next[6])
            prg_slot[1] = !prg_slot[1];
        if (prg_slot[1])
            prg_raw = {PRG_FIXED_HI, prg_slot[0]};
        else if (prg_slot[0])
            prg_raw = bank_regs_next[7];
        else
            prg_raw = bank_regs_next[6];

        // chr: two 2 KB pairs then four 1 KB banks, pointer bit 7 swaps halves
        chr_slot = ppu_addr[12:10] ^ {bank_pointer_next[7], 2'b00};
        unique case (chr_slot)
            3'd0:    chr_raw = {bank_regs_next[0][7:1], 1'b0};
            3'd1:    chr_raw = {bank_regs_next[0][7:1], 1'b1};
            3'd2:    chr_raw = {bank_regs_next[1][7:1], 1'b0};
            3'd3:    chr_raw = {bank_regs_next[1][7:1], 1'b1};
            3'd4:    chr_raw = bank_regs_next[2];
            3'd5:    chr_raw = bank_regs_next[3];
            3'd6:    chr_raw = bank_regs_next[4];
            default: chr_raw = bank_regs_next[5];
        endcase

        // work ram halves, protection as held before this word
        in_wram   = (cpu_addr[15:12] == WRAM_PAGE);
        high_half = cpu_addr[9];
        rd_this   = high_half ? protect_reg[3] : protect_reg[1];
        rd_other  = high_half ? protect_reg[1] : protect_reg[3];
        wr_this   = high_half ? protect_reg[2] : protect_reg[0];

        result             = '0;
        result.wram_action = WRAM_NONE;
        if (in_wram && mode == MODE_CPU_WRITE)
            result.wram_action = (rd_this && wr_this) ? WRAM_WRITE_RAM : WRAM_BLOCKED;
        else if (in_wram && mode == MODE_CPU_READ)
            result.wram_action = rd_this ? WRAM_READ_RAM :
                                 (rd_other ? WRAM_READ_ZERO : WRAM_OPEN_BUS);

        if (result.wram_action != WRAM_NONE)
            result.wram_offset = cpu_addr[9:0];
        result.prg_bank          = cpu_addr[15] ? ((prg_raw & prg_and_reg) | prg_or_reg) : 8'd0;
        result.chr_bank          = (chr_raw & chr_and_reg) | chr_or_reg;
        result.irq_active        = irq_pending_next;
        result.mirror_horizontal = mirror_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_pointer_reg <= 8'd0;
            bank_regs_reg    <= BANK_INIT;
            mirror_reg       <= 1'b0;
            protect_reg      <= 4'd0;
            counter_reg      <= 8'd0;
            reload_reg       <= 8'd0;
            irq_enable_reg   <= 1'b0;
            irq_pending_reg  <= 1'b0;
            filter_reg       <= 3'd0;
        end
        else if (in_fire)
        begin
            bank_pointer_reg <= bank_pointer_next;
            bank_regs_reg    <= bank_regs_next;
            mirror_reg       <= mirror_next;
            protect_reg      <= protect_next;
            counter_reg      <= counter_next;
            reload_reg       <= reload_next;
            irq_enable_reg   <= irq_enable_next;
            irq_pending_reg  <= irq_pending_next;
            filter_reg       <= filter_next;
        end
    end

    // output register and skid entry, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid entry, payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= result;
        end
        else if (in_fire)
        begin
            skid_data_reg <= result;
        end
    end

    // skid entry only fills behind a held output word
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // irq only raised while enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(irq_pending_reg) |-> $past(irq_enable_reg))
        else $error("irq raised while disabled");

    // protection bits survive only with work ram enabled in the pointer
    assert property (@(posedge clk) disable iff (!rst_n)
        (protect_reg != 4'd0) |-> bank_pointer_reg[5])
        else $error("work ram protection set while disabled");

    // filter never exceeds its load value
    assert property (@(posedge clk) disable iff (!rst_n)
        filter_reg <= FILTER_CYCLES)
        else $error("a12 filter out of range");

endmodule

// ===== tb/mapper_bank_switch_scanline_irq_tb.sv =====
// self-checking stream testbench for the scanline counter bank-switch mapper
`timescale 1ns / 100ps

module mapper_bank_switch_scanline_irq_tb;

    import mbs_pkg::*;

    localparam int HOLD_LEN = 48;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // mapper state as the predictor sees it
    byte_t      bank_ptr;
    byte_t      bank_reg [8];
    logic       mirror_flag;
    logic [3:0] protect;
    byte_t      scan_count;
    byte_t      scan_reload;
    logic       irq_en;
    logic       irq_pend;
    logic [2:0] a12_hold;
    byte_t      prg_and, prg_or, chr_and, chr_or;

    result_t expected_results [$];

    bit steady_flow;
    int holds_requested;
    int holds_served;
    int hold_left;
    int mismatches;
    int items_sent;
    int words_checked;
    int irq_words;
    int mask_settings;

    mapper_bank_switch_scanline_irq u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // cpu_addr, write_data, ppu_addr, zero pad
        .s_tuser   (s_tuser),   // mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // prg_bank, chr_bank, wram_action, wram_offset,
                                // irq_active, mirror_horizontal, zero pad
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("mapper_bank_switch_scanline_irq verification failed");
        $finish;
    end

    // apply one item to the mapper state and return the word it should produce
    function automatic result_t mapper_step(input mode_t m, input logic [15:0] ca,
                                            input byte_t wd, input logic [13:0] pa);
        result_t      r;
        wram_action_t act;
        logic         in_wram, hi, rd_this, rd_other, wr_this, odd;
        logic [1:0]   pslot;
        logic [2:0]   cslot;
        byte_t        pb, cb;
        in_wram  = (ca[15:12] == WRAM_PAGE);
        hi       = ca[9];
        rd_this  = hi ? protect[3] : protect[1];
        rd_other = hi ? protect[1] : protect[3];
        wr_this  = hi ? protect[2] : protect[0];
        odd      = ca[0];
        act      = WRAM_NONE;
        case (m)
            MODE_CPU_WRITE:
            begin
                if (in_wram)
                    act = (rd_this && wr_this) ? WRAM_WRITE_RAM : WRAM_BLOCKED;
                else if (ca[15])
                begin
                    case (ca[15:13])
                        GRP_BANK:
                        begin
                            if (odd) bank_reg[bank_ptr[2:0]] = wd;
                            else bank_ptr = wd;
                            if (!bank_ptr[5]) protect = '0;
                        end
                        GRP_MIRROR:
                        begin
                            if (odd) protect = wd[7:4];
                            else mirror_flag = wd[0];
                            if (!bank_ptr[5]) protect = '0;
                        end
                        GRP_RELOAD:
                        begin
                            if (odd) scan_count = '0;
                            else scan_reload = wd;
                        end
                        default:
                        begin
                            irq_en = odd;
                            if (!odd) irq_pend = 1'b0;
                        end
                    endcase
                end
            end
            MODE_CPU_READ:
            begin
                if (in_wram)
                    act = rd_this ? WRAM_READ_RAM : (rd_other ? WRAM_READ_ZERO : WRAM_OPEN_BUS);
            end
            MODE_CPU_TICK:
            begin
                if (a12_hold != 0) a12_hold = a12_hold - 3'd1;
            end
            default:
            begin
                // an access with a12 high clocks the counter unless the filter still holds
                if (pa[12])
                begin
                    if (a12_hold == 0)
                    begin
                        if (scan_count == 0) scan_count = scan_reload;
                        else scan_count = scan_count - 8'd1;
                        if (scan_count == 0 && irq_en) irq_pend = 1'b1;
                    end
                    a12_hold = FILTER_CYCLES;
                end
            end
        endcase

        r = '0;
        // prg lookup, slots 0 and 2 swapped by pointer bit 6
        if (ca[15])
        begin
            pslot = ca[14:13];
            if (!pslot[0] && bank_ptr[6]) pslot[1] = ~pslot[1];
            pb = pslot[1] ? {PRG_FIXED_HI, pslot[0]} : bank_reg[{2'b11, pslot[0]}];
            r.prg_bank = (pb & prg_and) | prg_or;
        end
        // chr lookup, halves swapped by pointer bit 7
        cslot = pa[12:10];
        if (bank_ptr[7]) cslot[2] = ~cslot[2];
        if (cslot[2]) cb = bank_reg[3'(cslot - 3'd2)];
        else cb = {bank_reg[cslot >> 1][7:1], cslot[0]};
        r.chr_bank          = (cb & chr_and) | chr_or;
        r.wram_action       = act;
        r.wram_offset       = (act != WRAM_NONE) ? ca[9:0] : 10'd0;
        r.irq_active        = irq_pend;
        r.mirror_horizontal = mirror_flag;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
    endtask

    // result checker, oldest expectation first
    always @(posedge clk)
    begin : check_results
        result_t want, got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (expected_results.size() == 0)
                flag_mismatch("unexpected word", 0, int'(m_tdata));
            else
            begin
                want = expected_results.pop_front();
                words_checked++;
                if (got.irq_active === 1'b1) irq_words++;
                if (got.prg_bank !== want.prg_bank)
                    flag_mismatch("prg_bank", want.prg_bank, got.prg_bank);
                if (got.chr_bank !== want.chr_bank)
                    flag_mismatch("chr_bank", want.chr_bank, got.chr_bank);
                if (got.wram_action !== want.wram_action)
                    flag_mismatch("wram_action", want.wram_action, got.wram_action);
                if (got.wram_offset !== want.wram_offset)
                    flag_mismatch("wram_offset", want.wram_offset, got.wram_offset);
                if (got.irq_active !== want.irq_active)
                    flag_mismatch("irq_active", want.irq_active, got.irq_active);
                if (got.mirror_horizontal !== want.mirror_horizontal)
                    flag_mismatch("mirror_horizontal", want.mirror_horizontal,
                                  got.mirror_horizontal);
            end
        end
    end

    // output side: random stalls, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_requested)
        begin
            m_tready     <= 1'b0;
            hold_left    <= HOLD_LEN - 1;
            holds_served <= holds_served + 1;
        end
        else if (steady_flow)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 11);
    end

    // offer one word, predict it once taken; entered and left just after a falling edge
    task automatic send_word(input mode_t m, input logic [15:0] ca, input byte_t wd,
                             input logic [13:0] pa);
        if (!steady_flow && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {2'b00, pa, wd, ca};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(mapper_step(m, ca, wd, pa));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input cfg_index_t idx, input byte_t val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PRG_AND: prg_and = val;
            CFG_PRG_OR:  prg_or  = val;
            CFG_CHR_AND: chr_and = val;
            default:     chr_or  = val;
        endcase
        @(negedge clk);
    endtask

    task automatic set_masks(input byte_t pa_m, input byte_t po_m, input byte_t ca_m,
                             input byte_t co_m);
        stop_and_drain();
        write_config(CFG_PRG_AND, pa_m);
        write_config(CFG_PRG_OR, po_m);
        write_config(CFG_CHR_AND, ca_m);
        write_config(CFG_CHR_OR, co_m);
        cfg_we <= 1'b0;
        @(negedge clk);
        mask_settings++;
    endtask

    // mostly well-formed mapper traffic with some fully random words
    task automatic send_random_items(input int count);
        int          sent, kind, burst;
        logic [15:0] ca;
        byte_t       wd;
        logic [13:0] pa;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(99);
            ca   = 16'($urandom);
            wd   = 8'($urandom);
            pa   = 14'($urandom);
            if (kind < 22)
            begin
                // register write; keep work ram enabled and reloads small most of the time
                ca[15] = 1'b1;
                if (ca[14:13] == 2'b00 && !ca[0] && $urandom_range(3) != 0) wd[5] = 1'b1;
                if (ca[14:13] == 2'b10 && !ca[0] && $urandom_range(3) != 0)
                    wd = 8'($urandom_range(0, 3));
                send_word(MODE_CPU_WRITE, ca, wd, pa);
                sent++;
            end
            else if (kind < 38)
            begin
                ca[15:12] = WRAM_PAGE;
                send_word($urandom_range(1) ? MODE_CPU_READ : MODE_CPU_WRITE, ca, wd, pa);
                sent++;
            end
            else if (kind < 60)
            begin
                // tick bursts let the a12 filter run out
                burst = $urandom_range(1, 7);
                repeat (burst)
                begin
                    send_word(MODE_CPU_TICK, 16'($urandom), 8'($urandom), 14'($urandom));
                end
                sent += burst;
            end
            else if (kind < 88)
            begin
                send_word(MODE_PPU, ca, wd, pa);
                sent++;
            end
            else
            begin
                send_word(mode_t'($urandom_range(3)), ca, wd, pa);
                sent++;
            end
        end
    endtask

    // protection, mirroring, bank pointer, counter and irq basics from reset
    task automatic test_directed_basics();
        send_word(MODE_CPU_READ,  16'h7000, 8'h00, 14'h0000);  // disabled ram reads open bus
        send_word(MODE_CPU_WRITE, 16'h6FFF, 8'hFF, 14'h3FFF);  // below ram window
        send_word(MODE_CPU_WRITE, 16'h8000, 8'hE0, 14'h0400);  // pointer with all swaps
        send_word(MODE_CPU_WRITE, 16'hA001, 8'hB0, 14'h0800);  // protect low rw, high ro
        send_word(MODE_CPU_READ,  16'h7000, 8'h00, 14'h0C00);
        send_word(MODE_CPU_READ,  16'h7200, 8'h00, 14'h1000);
        send_word(MODE_CPU_WRITE, 16'h73FF, 8'h55, 14'h1400);  // high half not writable
        send_word(MODE_CPU_WRITE, 16'h7001, 8'hAA, 14'h1800);
        send_word(MODE_CPU_WRITE, 16'hA001, 8'h20, 14'h1C00);  // only low half readable
        send_word(MODE_CPU_READ,  16'h7200, 8'h00, 14'h0000);  // unreadable half reads zero
        send_word(MODE_CPU_WRITE, 16'h8001, 8'hFF, 14'h0000);
        send_word(MODE_CPU_WRITE, 16'hA000, 8'h01, 14'h0000);  // horizontal mirroring
        send_word(MODE_CPU_WRITE, 16'hE001, 8'h00, 14'h0000);  // irq enable
        send_word(MODE_PPU,       16'h0000, 8'h00, 14'h1000);  // zero reload fires at once
        send_word(MODE_PPU,       16'h0000, 8'h00, 14'h3FFF);  // filtered
        send_word(MODE_CPU_TICK,  16'hFFFF, 8'hFF, 14'h3FFF);
        send_word(MODE_CPU_WRITE, 16'hE000, 8'h00, 14'h0000);  // irq off and acknowledged
        send_word(MODE_CPU_WRITE, 16'hC000, 8'h01, 14'h0000);
        send_word(MODE_CPU_WRITE, 16'hC001, 8'h00, 14'h0000);  // counter clear
        send_word(MODE_CPU_WRITE, 16'h8000, 8'h00, 14'h0000);  // pointer bit 5 low clears
        send_word(MODE_CPU_READ,  16'h7FFF, 8'h00, 14'h3FFF);
        send_word(MODE_CPU_READ,  16'hFFFF, 8'h00, 14'h2FFF);
        send_word(MODE_CPU_TICK,  16'h0000, 8'h00, 14'h0000);
        send_word(MODE_CPU_READ,  16'h0000, 8'h00, 14'h1FFF);
        send_random_items(120);
    endtask

    // bank masks at both extremes and in between
    task automatic test_mask_settings();
        set_masks(8'h00, 8'h00, 8'h00, 8'h00);
        send_random_items(90);
        set_masks(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_random_items(90);
        set_masks(8'h0F, 8'hA0, 8'hF0, 8'h05);
        send_random_items(90);
        set_masks(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_random_items(90);
        set_masks(8'hFF, 8'h00, 8'hFF, 8'h00);
    endtask

    // back-to-back words with no stalls on either side
    task automatic test_steady_stream();
        steady_flow = 1'b1;
        send_random_items(100);
        steady_flow = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_holdoff();
        holds_requested++;
        send_random_items(30);
    endtask

    // sender goes quiet until every word is back, then resumes
    task automatic test_sender_pause();
        send_random_items(20);
        stop_and_drain();
        send_random_items(20);
    endtask

    initial
    begin
        bank_ptr    = '0;
        bank_reg    = BANK_INIT;
        mirror_flag = 1'b0;
        protect     = '0;
        scan_count  = '0;
        scan_reload = '0;
        irq_en      = 1'b0;
        irq_pend    = 1'b0;
        a12_hold    = '0;
        prg_and     = 8'hFF;
        prg_or      = 8'h00;
        chr_and     = 8'hFF;
        chr_or      = 8'h00;
        mask_settings = 1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_basics();
        test_mask_settings();
        test_steady_stream();
        test_output_holdoff();
        test_sender_pause();

        stop_and_drain();
        repeat (10) @(negedge clk);
        if (expected_results.size() != 0)
            flag_mismatch("words never returned", 0, expected_results.size());

        $display("run: %0d items over %0d mask settings, %0d words checked",
                 items_sent, mask_settings, words_checked);
        $display("run: %0d words with irq high, %0d mismatches", irq_words, mismatches);
        if (mismatches == 0)
            $display("mapper_bank_switch_scanline_irq verification clean");
        else
            $display("mapper_bank_switch_scanline_irq verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/mbs_pkg.sv
rtl/mapper_bank_switch_scanline_irq.sv
tb/mapper_bank_switch_scanline_irq_tb.sv
